### design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants, types and functions of the (16,8) block codec.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int WORD_BITS = 16;
    localparam int DATA_BITS = 8;
    localparam int SYN_BITS  = WORD_BITS - DATA_BITS;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic {
        MODE_SINGLE = 1'b0,
        MODE_PAIR   = 1'b1
    } t_mode;

    // Column i of H, bit r = H[r][i]; columns 8..15 are the identity.
    localparam logic [SYN_BITS-1:0] HCOL [WORD_BITS] = '{
        8'h0F, 8'h33, 8'hED, 8'hDB, 8'hAA, 8'hD5, 8'h6A, 8'hDB,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    // Stage 1 -> stage 2 payload
    typedef struct packed {
        logic                 vld;
        t_cmd                 cmd;
        logic [WORD_BITS-1:0] word;
        logic [SYN_BITS-1:0]  syn;
    } t_syn_beat;

    // Stage 2 -> stage 3 payload
    typedef struct packed {
        logic                 vld;
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] mask;
        logic [SYN_BITS-1:0]  syn;
        logic                 err;
    } t_fix_beat;

    function automatic logic [SYN_BITS-1:0] syndrome_of(input logic [WORD_BITS-1:0] w);
        logic [SYN_BITS-1:0] s;
        s = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                s = s ^ HCOL[i];
            end
        end
        return s;
    endfunction

    // Bits to flip for a given syndrome. Pair mode: bit i flips once for
    // every partner j whose column XOR with column i hits the syndrome.
    function automatic logic [WORD_BITS-1:0] toggle_mask(input logic [SYN_BITS-1:0] s,
                                                          input t_mode mode);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (mode == MODE_SINGLE) begin
                m[i] = (HCOL[i] == s);
            end else begin
                for (int j = 0; j < WORD_BITS; j++) begin
                    if ((i != j) && ((HCOL[i] ^ HCOL[j]) == s)) begin
                        m[i] = ~m[i];
                    end
                end
            end
        end
        return m;
    endfunction

endpackage

### design/lbc_syn_stage.sv
// ----------------------------------------------------------------------------
// lbc_syn_stage
// Input stage: selects the word to check and registers it with its syndrome.
// ----------------------------------------------------------------------------
module lbc_syn_stage import lbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_cmd                 i_cmd,
    input  logic [DATA_BITS-1:0] i_data_byte,
    input  logic [WORD_BITS-1:0] i_received_word,
    input  logic                 i_ready,
    output t_syn_beat            o_beat
);

    logic                 r_vld;
    t_cmd                 r_cmd;
    logic [WORD_BITS-1:0] r_word;
    logic [SYN_BITS-1:0]  r_syn;
    logic [WORD_BITS-1:0] n_word;

    assign o_ready = !r_vld || i_ready;

    // encode: syndrome over the data half alone is the parity byte
    always_comb begin
        n_word = (i_cmd == CMD_DECODE) ? i_received_word
                                       : {{SYN_BITS{1'b0}}, i_data_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd  <= i_cmd;
            r_word <= n_word;
            r_syn  <= syndrome_of(n_word);
        end
    end

    assign o_beat = '{vld: r_vld, cmd: r_cmd, word: r_word, syn: r_syn};

endmodule

### design/lbc_fix_stage.sv
// ----------------------------------------------------------------------------
// lbc_fix_stage
// Middle stage: matches the syndrome against H columns or column pairs and
// registers the flip mask, or builds the codeword for an encode beat.
// ----------------------------------------------------------------------------
module lbc_fix_stage import lbc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mode     i_mode,
    input  t_syn_beat i_beat,
    output logic      o_ready,
    input  logic      i_ready,
    output t_fix_beat o_beat
);

    logic                 r_vld;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] r_mask;
    logic [SYN_BITS-1:0]  r_syn;
    logic                 r_err;

    logic [WORD_BITS-1:0] n_word;
    logic [WORD_BITS-1:0] n_mask;
    logic [SYN_BITS-1:0]  n_syn;
    logic                 n_err;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        if (i_beat.cmd == CMD_DECODE) begin
            n_word = i_beat.word;
            n_syn  = i_beat.syn;
            n_err  = |i_beat.syn;
            n_mask = n_err ? toggle_mask(i_beat.syn, i_mode) : '0;
        end else begin
            n_word = {i_beat.syn, i_beat.word[DATA_BITS-1:0]};
            n_syn  = '0;
            n_err  = 1'b0;
            n_mask = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_beat.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_beat.vld) begin
            r_word <= n_word;
            r_mask <= n_mask;
            r_syn  <= n_syn;
            r_err  <= n_err;
        end
    end

    assign o_beat = '{vld: r_vld, word: r_word, mask: r_mask, syn: r_syn, err: r_err};

endmodule

### design/linear_block_code_16_8_codec.sv
// ----------------------------------------------------------------------------
// linear_block_code_16_8_codec
// Systematic (16,8) block encoder and syndrome corrector, three-stage pipe.
// ----------------------------------------------------------------------------
// Takes one beat per clock while not stalled and returns one result beat per
// input beat, registered in turn by each stage. The stages are the syndrome
// XOR tree, the column / column-pair match that builds the flip mask, and the
// output register that applies the mask. Each stage holds its beat under
// backpressure and frees itself as soon as the next one moves, so a full pipe
// keeps one beat per cycle while the output is not stalled. correction_mode is
// sampled in the match stage; write it only while the pipe is empty.
module linear_block_code_16_8_codec import lbc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [0:0]  i_cfg_wdata,      // correction_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,     // [7:0] data_byte, [23:8] received_word
    input  logic [0:0]  s_axis_tuser,     // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata      // [15:0] codeword, [23:16] corrected_byte,
                                          // [31:24] syndrome, [32] error_seen, rest 0
);

    t_mode     r_mode;
    t_syn_beat syn_beat;
    t_fix_beat fix_beat;
    logic      fix_ready;
    logic      out_ready;

    logic                 r_out_vld;
    logic [WORD_BITS-1:0] r_out_word;
    logic [SYN_BITS-1:0]  r_out_syn;
    logic                 r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SINGLE;
        end else if (i_cfg_wen) begin
            r_mode <= t_mode'(i_cfg_wdata[0]);
        end
    end

    lbc_syn_stage u_syn (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_cmd           (t_cmd'(s_axis_tuser[0])),
        .i_data_byte     (s_axis_tdata[7:0]),
        .i_received_word (s_axis_tdata[23:8]),
        .i_ready         (fix_ready),
        .o_beat          (syn_beat)
    );

    lbc_fix_stage u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_beat  (syn_beat),
        .o_ready (fix_ready),
        .i_ready (out_ready),
        .o_beat  (fix_beat)
    );

    // output stage: apply flip mask
    assign out_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= fix_beat.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && fix_beat.vld) begin
            r_out_word <= fix_beat.word ^ fix_beat.mask;
            r_out_syn  <= fix_beat.syn;
            r_out_err  <= fix_beat.err;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out_err, r_out_syn, r_out_word[DATA_BITS-1:0], r_out_word};

    // error flag tracks a nonzero syndrome on every delivered beat
    a_err_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[31:24] != 8'h00)))
        else $error("error_seen disagrees with syndrome");

    // a stalled middle-stage beat is neither dropped nor replaced
    a_fix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fix_beat.vld && !out_ready) |=> (fix_beat.vld && $stable(fix_beat.word)
                                          && $stable(fix_beat.mask)))
        else $error("middle stage lost a stalled beat");

    // an accepted input beat always lands in the first stage
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> syn_beat.vld)
        else $error("accepted beat missing in first stage");

endmodule
